// ----- hdl/bpio_pkg.sv -----
// ============================================================================
// bpio_pkg: shared types and constants for the block partition index owner
// Widths, register indexes, the derive sequencer states and the structs
// passed between the top level and its submodules.
// ============================================================================
`default_nettype none

package bpio_pkg;

    localparam int INDEX_BITS     = 32;
    localparam int PART_BITS      = 16;
    localparam int WIDE_BITS      = INDEX_BITS + PART_BITS;
    localparam int CFG_DATA_BITS  = (INDEX_BITS > PART_BITS) ? INDEX_BITS : PART_BITS;
    localparam int CFG_INDEX_BITS = 2;
    localparam int STEP_BITS      = $clog2(INDEX_BITS);

    typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

    localparam cfg_index_t REG_TOTAL_LENGTH = cfg_index_t'(0);
    localparam cfg_index_t REG_PART_COUNT   = cfg_index_t'(1);
    localparam cfg_index_t REG_MY_PART      = cfg_index_t'(2);

    localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(INDEX_BITS - 1);

    typedef enum logic [2:0] {
        DRV_IDLE,
        DRV_LOAD,
        DRV_DIVIDE,
        DRV_MULTIPLY,
        DRV_SUM
    } drv_state_t;

    // Derived split of the vector, valid whenever busy is low
    typedef struct packed {
        logic                  busy;
        logic [INDEX_BITS-1:0] total_length;
        logic [PART_BITS-1:0]  my_part;
        logic [INDEX_BITS-1:0] base_quotient;
        logic [PART_BITS-1:0]  long_part_count;
        logic [INDEX_BITS-1:0] split_point;
    } bpio_cfg_t;

    // Per-item data riding alongside the divider
    typedef struct packed {
        logic                  in_range;
        logic                  long_part;
        logic                  div_zero;
        logic [INDEX_BITS-1:0] idx;
    } bpio_side_t;

endpackage

`default_nettype wire

// ----- hdl/bpio_derive.sv -----
// ============================================================================
// bpio_derive: configuration registers and split derivation
// Holds the three registers and, after every write, works out the base
// quotient, the count of long parts and the split point with a radix-2
// divider followed by a multiply and an add.
// ============================================================================
`default_nettype none

module bpio_derive (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [bpio_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [bpio_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    output bpio_pkg::bpio_cfg_t                      cfg
);

    localparam int IB = bpio_pkg::INDEX_BITS;
    localparam int PB = bpio_pkg::PART_BITS;

    bpio_pkg::drv_state_t state_reg, state_next;

    logic [IB-1:0] total_reg;
    logic [PB-1:0] part_count_reg;
    logic [PB-1:0] my_part_reg;
    logic [IB-1:0] quotient_reg;
    logic [PB-1:0] long_count_reg;
    logic [IB-1:0] split_reg;

    logic [IB-1:0]                  dvd_reg;
    logic [PB-1:0]                  rem_reg;
    logic [PB-1:0]                  divisor_reg;
    logic [bpio_pkg::STEP_BITS-1:0] step_reg;
    logic [IB-1:0]                  prod_reg;

    logic                          cfg_write;
    logic                          busy;
    logic                          do_load;
    logic                          do_divide;
    logic                          do_multiply;
    logic                          do_sum;
    logic [PB:0]                   rem_shift;
    logic                          rem_ge;
    logic [PB:0]                   rem_diff;
    logic [bpio_pkg::WIDE_BITS-1:0] prod_full;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bpio_pkg::DRV_IDLE:     state_next = bpio_pkg::DRV_IDLE;
            bpio_pkg::DRV_LOAD:     state_next = bpio_pkg::DRV_DIVIDE;
            bpio_pkg::DRV_DIVIDE:
            begin
                if (step_reg == bpio_pkg::LAST_STEP)
                    state_next = bpio_pkg::DRV_MULTIPLY;
            end
            bpio_pkg::DRV_MULTIPLY: state_next = bpio_pkg::DRV_SUM;
            bpio_pkg::DRV_SUM:      state_next = bpio_pkg::DRV_IDLE;
            default:                state_next = bpio_pkg::DRV_IDLE;
        endcase
        // a write restarts the derivation from the new register values
        if (cfg_write)
            state_next = bpio_pkg::DRV_LOAD;
    end

    // Outputs of the sequencer
    always_comb
    begin
        busy        = 1'b1;
        do_load     = 1'b0;
        do_divide   = 1'b0;
        do_multiply = 1'b0;
        do_sum      = 1'b0;
        case (state_reg)
            bpio_pkg::DRV_IDLE:     busy        = 1'b0;
            bpio_pkg::DRV_LOAD:     do_load     = 1'b1;
            bpio_pkg::DRV_DIVIDE:   do_divide   = 1'b1;
            bpio_pkg::DRV_MULTIPLY: do_multiply = 1'b1;
            bpio_pkg::DRV_SUM:      do_sum      = 1'b1;
            default:                busy        = 1'b1;
        endcase
    end

    // One quotient bit per cycle; quotient bits shift into the dividend
    assign rem_shift = {rem_reg, dvd_reg[IB-1]};
    assign rem_ge    = rem_shift >= {1'b0, divisor_reg};
    assign rem_diff  = rem_shift - {1'b0, divisor_reg};
    assign prod_full = bpio_pkg::WIDE_BITS'(rem_reg) * bpio_pkg::WIDE_BITS'(dvd_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= bpio_pkg::DRV_IDLE;
            total_reg      <= IB'(1);
            part_count_reg <= PB'(1);
            my_part_reg    <= '0;
            quotient_reg   <= IB'(1);
            long_count_reg <= '0;
            split_reg      <= '0;
            step_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    bpio_pkg::REG_TOTAL_LENGTH: total_reg      <= cfg_data[IB-1:0];
                    bpio_pkg::REG_PART_COUNT:   part_count_reg <= cfg_data[PB-1:0];
                    bpio_pkg::REG_MY_PART:      my_part_reg    <= cfg_data[PB-1:0];
                    default:                    ;
                endcase
            end
            if (do_load)
                step_reg <= '0;
            else if (do_divide)
                step_reg <= step_reg + 1'b1;
            if (do_multiply)
            begin
                quotient_reg   <= dvd_reg;
                long_count_reg <= rem_reg;
            end
            if (do_sum)
                split_reg <= prod_reg + IB'(rem_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_load)
        begin
            dvd_reg     <= total_reg;
            rem_reg     <= '0;
            // treat a zero part count as one
            divisor_reg <= (part_count_reg == '0) ? PB'(1) : part_count_reg;
        end
        else if (do_divide)
        begin
            dvd_reg <= {dvd_reg[IB-2:0], rem_ge};
            rem_reg <= rem_ge ? rem_diff[PB-1:0] : rem_shift[PB-1:0];
        end
        // r * (q + 1) taken as r * q, then plus r
        if (do_multiply)
            prod_reg <= prod_full[IB-1:0];
    end

    assign cfg.busy            = busy;
    assign cfg.total_length    = total_reg;
    assign cfg.my_part         = my_part_reg;
    assign cfg.base_quotient   = quotient_reg;
    assign cfg.long_part_count = long_count_reg;
    assign cfg.split_point     = split_reg;

endmodule

`default_nettype wire

// ----- hdl/bpio_div_pipe.sv -----
// ============================================================================
// bpio_div_pipe: pipelined restoring divider
// One quotient bit per stage, PART_BITS stages, for quotients known to fit
// in PART_BITS bits. Each stage holds its beat until the next one frees.
// ============================================================================
`default_nettype none

module bpio_div_pipe (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic [bpio_pkg::INDEX_BITS-1:0]  in_dividend,
    input  wire logic [bpio_pkg::INDEX_BITS-1:0]  in_divisor,
    input  wire bpio_pkg::bpio_side_t              in_side,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic [bpio_pkg::PART_BITS-1:0]        out_quotient,
    output logic [bpio_pkg::INDEX_BITS-1:0]       out_remainder,
    output logic [bpio_pkg::INDEX_BITS-1:0]       out_divisor,
    output bpio_pkg::bpio_side_t                   out_side
);

    localparam int IB     = bpio_pkg::INDEX_BITS;
    localparam int PB     = bpio_pkg::PART_BITS;
    localparam int WB     = bpio_pkg::WIDE_BITS;
    localparam int STAGES = bpio_pkg::PART_BITS;

    logic [STAGES:0]       vld;
    logic [STAGES:0]       rdy;
    logic [IB-1:0]         rem_a  [0:STAGES];
    logic [IB-1:0]         dsr_a  [0:STAGES];
    logic [PB-1:0]         quo_a  [0:STAGES];
    bpio_pkg::bpio_side_t  side_a [0:STAGES];

    assign vld[0]    = in_valid;
    assign rem_a[0]  = in_dividend;
    assign dsr_a[0]  = in_divisor;
    assign quo_a[0]  = '0;
    assign side_a[0] = in_side;
    assign rdy[STAGES] = out_ready;

    for (genvar k = 0; k < STAGES; k++)
    begin : g_stage
        localparam int SHIFT = STAGES - 1 - k;

        logic                 val_reg;
        logic [IB-1:0]        rem_reg;
        logic [IB-1:0]        dsr_reg;
        logic [PB-1:0]        quo_reg;
        bpio_pkg::bpio_side_t side_reg;

        logic [WB-1:0] trial;
        logic [WB-1:0] rem_wide;
        logic [WB-1:0] diff;
        logic          ge;

        assign trial    = WB'(dsr_a[k]) << SHIFT;
        assign rem_wide = WB'(rem_a[k]);
        assign ge       = rem_wide >= trial;
        assign diff     = rem_wide - trial;

        assign rdy[k] = !vld[k+1] || rdy[k+1];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                val_reg <= 1'b0;
            else if (rdy[k])
                val_reg <= vld[k];
        end

        always_ff @(posedge clk)
        begin
            if (rdy[k] && vld[k])
            begin
                rem_reg  <= ge ? diff[IB-1:0] : rem_a[k];
                quo_reg  <= quo_a[k] | (PB'(ge) << SHIFT);
                dsr_reg  <= dsr_a[k];
                side_reg <= side_a[k];
            end
        end

        assign vld[k+1]    = val_reg;
        assign rem_a[k+1]  = rem_reg;
        assign dsr_a[k+1]  = dsr_reg;
        assign quo_a[k+1]  = quo_reg;
        assign side_a[k+1] = side_reg;
    end

    assign in_ready      = rdy[0];
    assign out_valid     = vld[STAGES];
    assign out_quotient  = quo_a[STAGES];
    assign out_remainder = rem_a[STAGES];
    assign out_divisor   = dsr_a[STAGES];
    assign out_side      = side_a[STAGES];

endmodule

`default_nettype wire

// ----- hdl/block_partition_index_owner.sv -----
// ============================================================================
// block_partition_index_owner: owner and local offset of a block-split index
// Locates a global index in a vector split into contiguous parts, the first
// total_length mod part_count parts one element longer than the rest.
// ============================================================================
// Takes one index per cycle while in_stall is low; each result passes through
// one entry stage, one stage per quotient bit of the pipelined divider, and
// the output register. After each configuration write the input stalls while
// the radix-2 divider, a multiply and an add derive the base part size, the
// count of long parts and the split point. Indices at or beyond total_length
// come back with in_range low and every other field zero.
`default_nettype none

module block_partition_index_owner (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic [bpio_pkg::INDEX_BITS-1:0]      global_index,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic                                      in_range,
    output logic [bpio_pkg::PART_BITS-1:0]            owner_part,
    output logic [bpio_pkg::INDEX_BITS-1:0]           part_begin,
    output logic [bpio_pkg::INDEX_BITS-1:0]           part_size,
    output logic [bpio_pkg::INDEX_BITS-1:0]           local_offset,
    output logic                                      is_mine,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [bpio_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire logic [bpio_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

    localparam int IB = bpio_pkg::INDEX_BITS;
    localparam int PB = bpio_pkg::PART_BITS;

    bpio_pkg::bpio_cfg_t cfg;

    logic          in_take;
    logic          entry_ready;
    logic          entry_valid_reg;
    logic [IB-1:0] entry_idx_reg;

    logic                 prep_in_range;
    logic                 prep_long;
    logic [IB-1:0]        prep_dividend;
    logic [IB-1:0]        prep_divisor;
    bpio_pkg::bpio_side_t prep_side;

    logic                 div_ready;
    logic                 div_valid;
    logic [PB-1:0]        div_quotient;
    logic [IB-1:0]        div_remainder;
    logic [IB-1:0]        div_divisor;
    bpio_pkg::bpio_side_t div_side;

    logic          out_ready;
    logic          out_valid_reg;
    logic [PB-1:0] owner_next;
    logic [IB-1:0] begin_next;
    logic [IB-1:0] offset_next;
    logic          in_range_reg;
    logic [PB-1:0] owner_reg;
    logic [IB-1:0] begin_reg;
    logic [IB-1:0] size_reg;
    logic [IB-1:0] offset_reg;
    logic          mine_reg;

    bpio_derive u_derive (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Entry stage
    assign entry_ready = !entry_valid_reg || div_ready;
    assign in_stall    = cfg.busy || !entry_ready;
    assign in_take     = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            entry_valid_reg <= 1'b0;
        else if (entry_ready)
            entry_valid_reg <= in_take;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            entry_idx_reg <= global_index;
    end

    // Pick the long or the short run of parts and set up the divide
    assign prep_in_range = entry_idx_reg < cfg.total_length;
    assign prep_long     = entry_idx_reg < cfg.split_point;
    assign prep_dividend = prep_long ? entry_idx_reg : entry_idx_reg - cfg.split_point;
    assign prep_divisor  = prep_long ? cfg.base_quotient + IB'(1) : cfg.base_quotient;

    assign prep_side.in_range  = prep_in_range;
    assign prep_side.long_part = prep_long;
    assign prep_side.div_zero  = (prep_divisor == '0);
    assign prep_side.idx       = entry_idx_reg;

    bpio_div_pipe u_div (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (entry_valid_reg),
        .in_ready      (div_ready),
        .in_dividend   (prep_dividend),
        .in_divisor    (prep_divisor),
        .in_side       (prep_side),
        .out_valid     (div_valid),
        .out_ready     (out_ready),
        .out_quotient  (div_quotient),
        .out_remainder (div_remainder),
        .out_divisor   (div_divisor),
        .out_side      (div_side)
    );

    // The remainder is the offset inside the part; begin follows from it
    always_comb
    begin
        if (div_side.div_zero)
        begin
            owner_next  = '0;
            begin_next  = '0;
            offset_next = div_side.idx;
        end
        else
        begin
            owner_next  = div_side.long_part ? div_quotient
                                             : div_quotient + cfg.long_part_count;
            begin_next  = div_side.idx - div_remainder;
            offset_next = div_remainder;
        end
    end

    // Output register
    assign out_ready = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_ready)
            out_valid_reg <= div_valid;
    end

    always_ff @(posedge clk)
    begin
        if (out_ready && div_valid)
        begin
            in_range_reg <= div_side.in_range;
            if (div_side.in_range)
            begin
                owner_reg  <= owner_next;
                begin_reg  <= begin_next;
                size_reg   <= div_divisor;
                offset_reg <= offset_next;
                mine_reg   <= (owner_next == cfg.my_part);
            end
            else
            begin
                owner_reg  <= '0;
                begin_reg  <= '0;
                size_reg   <= '0;
                offset_reg <= '0;
                mine_reg   <= 1'b0;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign in_range     = in_range_reg;
    assign owner_part   = owner_reg;
    assign part_begin   = begin_reg;
    assign part_size    = size_reg;
    assign local_offset = offset_reg;
    assign is_mine      = mine_reg;

`ifndef SYNTHESIS
    a_cfg_write_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> in_stall)
        else $error("input not stalled after a configuration write");

    a_out_of_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !in_range |-> (owner_part == '0 && part_begin == '0 &&
            part_size == '0 && local_offset == '0 && !is_mine))
        else $error("out-of-range beat carries nonzero fields");

    a_offset_in_part: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && in_range |-> (part_size != '0 && local_offset < part_size))
        else $error("local offset outside the owning part");
`endif

endmodule

`default_nettype wire
